FILE: src/rc4hex_pkg.sv
package rc4hex_pkg;

  localparam int unsigned MaxKeyBytes = 16;

  localparam logic [6:0] ChrZero = 7'h30;
  localparam logic [6:0] ChrAlpha = 7'h41;
  localparam logic [3:0] NibTen = 4'hA;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       message_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [6:0] hex_high_char;
    logic [6:0] hex_low_char;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RA_I,
    RA_I1,
    RA_JSUM,
    RA_PAIR
  } rsel_e;

  typedef enum logic {
    WA_I,
    WA_J
  } wsel_e;

  typedef enum logic [1:0] {
    WD_I,
    WD_SI,
    WD_SJ,
    WD_RD
  } wdat_e;

  typedef enum logic [1:0] {
    I_KEEP,
    I_ZERO,
    I_INC,
    I_GO
  } iop_e;

  typedef enum logic [1:0] {
    J_KEEP,
    J_ZERO,
    J_SUM
  } jop_e;

  typedef enum logic [1:0] {
    K_KEEP,
    K_ZERO,
    K_STEP
  } kop_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_WAIT_IN,
    JMP_FILL,
    JMP_LOOP,
    JMP_OUT
  } jmp_e;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_G1    = 4'd1;
  localparam step_t STEP_G2    = 4'd2;
  localparam step_t STEP_G3    = 4'd3;
  localparam step_t STEP_KS0   = 4'd4;
  localparam step_t STEP_FILL  = 4'd5;
  localparam step_t STEP_R0    = 4'd6;
  localparam step_t STEP_R1    = 4'd7;
  localparam step_t STEP_R2    = 4'd8;
  localparam step_t STEP_R3    = 4'd9;
  localparam step_t STEP_KSEND = 4'd10;

  typedef struct packed {
    logic  re;
    rsel_e rsel;
    logic  we;
    wsel_e wsel;
    wdat_e wdat;
    iop_e  iop;
    jop_e  jop;
    kop_e  kop;
    logic  key_add;
    logic  ld_si;
    logic  ld_sj;
    logic  ld_out;
    jmp_e  jmp;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic out_blocked;
  } stat_t;

  function automatic ctrl_t ucode_rom(input step_t pc);
    ctrl_t c;
    c = '{re: 1'b0, rsel: RA_I, we: 1'b0, wsel: WA_I, wdat: WD_I, iop: I_KEEP,
          jop: J_KEEP, kop: K_KEEP, key_add: 1'b0, ld_si: 1'b0, ld_sj: 1'b0,
          ld_out: 1'b0, jmp: JMP_NEXT, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        c.re = 1'b1; c.rsel = RA_I1; c.iop = I_GO;
        c.jmp = JMP_WAIT_IN; c.target = STEP_KS0;
      end
      STEP_G1: begin
        c.re = 1'b1; c.rsel = RA_JSUM; c.jop = J_SUM; c.ld_si = 1'b1;
      end
      STEP_G2: begin
        c.re = 1'b1; c.rsel = RA_PAIR; c.ld_sj = 1'b1;
        c.we = 1'b1; c.wsel = WA_J; c.wdat = WD_SI;
      end
      STEP_G3: begin
        c.we = 1'b1; c.wsel = WA_I; c.wdat = WD_SJ; c.ld_out = 1'b1;
        c.jmp = JMP_OUT; c.target = STEP_IDLE;
      end
      STEP_KS0: begin
        c.iop = I_ZERO; c.jop = J_ZERO; c.kop = K_ZERO;
      end
      STEP_FILL: begin
        c.we = 1'b1; c.wsel = WA_I; c.wdat = WD_I; c.iop = I_INC;
        c.jmp = JMP_FILL;
      end
      STEP_R0: begin
        c.re = 1'b1; c.rsel = RA_I;
      end
      STEP_R1: begin
        c.re = 1'b1; c.rsel = RA_JSUM; c.key_add = 1'b1; c.jop = J_SUM;
        c.ld_si = 1'b1;
      end
      STEP_R2: begin
        c.we = 1'b1; c.wsel = WA_I; c.wdat = WD_RD;
      end
      STEP_R3: begin
        c.we = 1'b1; c.wsel = WA_J; c.wdat = WD_SI; c.iop = I_INC;
        c.kop = K_STEP; c.jmp = JMP_LOOP; c.target = STEP_R0;
      end
      STEP_KSEND: begin
        c.re = 1'b1; c.rsel = RA_I1; c.iop = I_INC; c.jop = J_ZERO;
        c.jmp = JMP_GOTO; c.target = STEP_G1;
      end
      default: begin
        c.jmp = JMP_GOTO; c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] r;
    if (nib < NibTen) begin
      r = ChrZero + {3'b000, nib};
    end else begin
      r = ChrAlpha + {3'b000, nib} - {3'b000, NibTen};
    end
    return r;
  endfunction

endpackage

FILE: src/rc4hex_sbox.sv
module rc4hex_sbox (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [256];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rc4hex_seq.sv
module rc4hex_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                msg_start_i,
  input  rc4hex_pkg::stat_t   stat_i,
  output logic                in_ready_o,
  output rc4hex_pkg::ctrl_t   ctrl_o
);

  rc4hex_pkg::step_t pc_q, pc_d;
  logic              sched_q, sched_d;
  logic              fire;
  rc4hex_pkg::ctrl_t ctrl;

  assign ctrl       = rc4hex_pkg::ucode_rom(pc_q);
  assign ctrl_o     = ctrl;
  assign in_ready_o = (pc_q == rc4hex_pkg::STEP_IDLE);
  assign fire       = in_valid_i & in_ready_o;

  always_comb begin
    pc_d    = pc_q + 4'd1;
    sched_d = sched_q;
    if (fire) begin
      sched_d = msg_start_i;
    end
    case (ctrl.jmp)
      rc4hex_pkg::JMP_NEXT: pc_d = pc_q + 4'd1;
      rc4hex_pkg::JMP_GOTO: pc_d = ctrl.target;
      rc4hex_pkg::JMP_WAIT_IN: begin
        if (!fire) begin
          pc_d = pc_q;
        end else if (msg_start_i) begin
          pc_d = ctrl.target;
        end
      end
      rc4hex_pkg::JMP_FILL: begin
        if (!stat_i.last) begin
          pc_d = pc_q;
        end else if (!sched_q) begin
          pc_d = rc4hex_pkg::STEP_IDLE;
        end
      end
      rc4hex_pkg::JMP_LOOP: begin
        if (!stat_i.last) begin
          pc_d = ctrl.target;
        end
      end
      rc4hex_pkg::JMP_OUT: begin
        pc_d = stat_i.out_blocked ? pc_q : ctrl.target;
      end
      default: pc_d = rc4hex_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= rc4hex_pkg::STEP_FILL;
      sched_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      sched_q <= sched_d;
    end
  end

endmodule

FILE: src/rc4hex_dp.sv
module rc4hex_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rc4hex_pkg::ctrl_t     ctrl_i,
  input  logic                  in_fire_i,
  input  rc4hex_pkg::in_item_t  in_item_i,
  input  logic [127:0]          key_i,
  input  logic [4:0]            key_len_i,
  input  logic                  out_ready_i,
  output rc4hex_pkg::stat_t     stat_o,
  output logic                  out_valid_o,
  output rc4hex_pkg::out_item_t out_item_o
);

  logic [7:0] i_q, i_d, j_q, j_d, si_q, sj_q, plain_q;
  logic [3:0] k_q, k_d;
  logic [7:0] rdata, raddr, waddr, wdata;
  logic [7:0] key_byte, jsum, pair, ks_addr, ks, cbyte;
  logic [4:0] len_eff, kp1;
  logic       out_valid_q, blocked, load;
  rc4hex_pkg::out_item_t out_q;

  rc4hex_sbox u_sbox (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign key_byte = key_i[{k_q, 3'b000} +: 8];
  assign jsum     = j_q + rdata + (ctrl_i.key_add ? key_byte : 8'd0);
  assign pair     = si_q + rdata;
  assign ks_addr  = si_q + sj_q;

  always_comb begin
    case (ctrl_i.rsel)
      rc4hex_pkg::RA_I:    raddr = i_q;
      rc4hex_pkg::RA_I1:   raddr = i_q + 8'd1;
      rc4hex_pkg::RA_JSUM: raddr = jsum;
      rc4hex_pkg::RA_PAIR: raddr = pair;
      default:             raddr = i_q;
    endcase
    waddr = (ctrl_i.wsel == rc4hex_pkg::WA_J) ? j_q : i_q;
    case (ctrl_i.wdat)
      rc4hex_pkg::WD_I:  wdata = i_q;
      rc4hex_pkg::WD_SI: wdata = si_q;
      rc4hex_pkg::WD_SJ: wdata = sj_q;
      rc4hex_pkg::WD_RD: wdata = rdata;
      default:           wdata = i_q;
    endcase
  end

  always_comb begin
    if (key_len_i == 5'd0) begin
      len_eff = 5'd1;
    end else if (key_len_i > 5'(rc4hex_pkg::MaxKeyBytes)) begin
      len_eff = 5'(rc4hex_pkg::MaxKeyBytes);
    end else begin
      len_eff = key_len_i;
    end
    kp1 = {1'b0, k_q} + 5'd1;
  end

  always_comb begin
    case (ctrl_i.iop)
      rc4hex_pkg::I_KEEP: i_d = i_q;
      rc4hex_pkg::I_ZERO: i_d = 8'd0;
      rc4hex_pkg::I_INC:  i_d = i_q + 8'd1;
      rc4hex_pkg::I_GO:   i_d = (in_fire_i && !in_item_i.message_start) ? i_q + 8'd1 : i_q;
      default:            i_d = i_q;
    endcase
    case (ctrl_i.jop)
      rc4hex_pkg::J_KEEP: j_d = j_q;
      rc4hex_pkg::J_ZERO: j_d = 8'd0;
      rc4hex_pkg::J_SUM:  j_d = jsum;
      default:            j_d = j_q;
    endcase
    case (ctrl_i.kop)
      rc4hex_pkg::K_KEEP: k_d = k_q;
      rc4hex_pkg::K_ZERO: k_d = 4'd0;
      rc4hex_pkg::K_STEP: k_d = (kp1 >= len_eff) ? 4'd0 : kp1[3:0];
      default:            k_d = k_q;
    endcase
  end

  // Forward the two swapped entries; the keystream read is taken before either swap write reaches the memory.
  always_comb begin
    if (ks_addr == i_q) begin
      ks = sj_q;
    end else if (ks_addr == j_q) begin
      ks = si_q;
    end else begin
      ks = rdata;
    end
    cbyte = plain_q ^ ks;
  end

  assign blocked = out_valid_q & ~out_ready_i;
  assign load    = ctrl_i.ld_out & ~blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= 8'd0;
      j_q         <= 8'd0;
      k_q         <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      plain_q <= in_item_i.plain_byte;
    end
    if (ctrl_i.ld_si) begin
      si_q <= rdata;
    end
    if (ctrl_i.ld_sj) begin
      sj_q <= rdata;
    end
    if (load) begin
      out_q.cipher_byte   <= cbyte;
      out_q.hex_high_char <= rc4hex_pkg::hex_char(cbyte[7:4]);
      out_q.hex_low_char  <= rc4hex_pkg::hex_char(cbyte[3:0]);
    end
  end

  assign stat_o.last        = (i_q == 8'hFF);
  assign stat_o.out_blocked = blocked;
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_q;

endmodule

FILE: src/rc4_cipher_hex_stream.sv
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  in_item_i  {plain_byte, message_start}
// out      out  out_valid_o/out_ready_i out_item_o {cipher_byte, hex_high_char, hex_low_char}
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Bytes are taken one at a time: a microcoded step sequence drives a 256x8
// permutation memory with separate read and write ports (three reads, two writes per byte).
// Message start first runs a fill, key mixing (steps R0 to R3 per round) and two
// setup steps (KS0, KSEND).
// After reset a fill loads the identity; no item is taken until it ends.
// A full output register stalls the last step; config writes are always taken.
module rc4_cipher_hex_stream (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rc4hex_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rc4hex_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i
);

  logic [63:0]       key_low_q, key_high_q;
  logic [4:0]        key_len_q;
  logic              in_fire;
  rc4hex_pkg::ctrl_t ctrl;
  rc4hex_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= 64'd0;
      key_high_q <= 64'd0;
      key_len_q  <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rc4hex_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        rc4hex_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        rc4hex_pkg::CFG_KEY_LEN:  key_len_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  rc4hex_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .msg_start_i (in_item_i.message_start),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  rc4hex_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_fire_i   (in_fire),
    .in_item_i   (in_item_i),
    .key_i       ({key_high_q, key_low_q}),
    .key_len_i   (key_len_q),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
